/* rtl/mtg_pkg.sv */
// shared constants, command and status types of the mersenne twister generator
`default_nettype none
package mtg_pkg;

  localparam int unsigned STATE_WORDS = 624;
  localparam int unsigned KEY_DEPTH   = 32;
  localparam int unsigned IDX_W       = 10;
  localparam int unsigned KEY_AW      = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int unsigned KC_W        = $clog2(KEY_DEPTH + 1);

  localparam logic [IDX_W-1:0] UNSEEDED  = IDX_W'(625);
  localparam logic [IDX_W-1:0] SHIFT_POS = IDX_W'(397);

  localparam logic [31:0] TWIST_CONST = 32'h9908_B0DF;
  localparam logic [31:0] HIGH_BIT    = 32'h8000_0000;
  localparam logic [31:0] TEMPER_B    = 32'h9D2C_5680;
  localparam logic [31:0] TEMPER_C    = 32'hEFC6_0000;
  localparam logic [31:0] SEED_MULT   = 32'd1812433253;
  localparam logic [31:0] ARRAY_BASE  = 32'd19650218;
  localparam logic [31:0] ARRAY_MULT1 = 32'd1664525;
  localparam logic [31:0] ARRAY_MULT2 = 32'd1566083941;

  localparam logic [1:0] FUNC_SEED = 2'd0;
  localparam logic [1:0] FUNC_KEY  = 2'd1;
  localparam logic [1:0] FUNC_GEN  = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_SEED0,
    OP_SEED0_BASE,
    OP_SEED_MUL,
    OP_SEED_WR,
    OP_KEY,
    OP_ARR_INIT,
    OP_A1,
    OP_B1,
    OP_A2,
    OP_B2,
    OP_FIN,
    OP_TW_PRE,
    OP_TW_A,
    OP_TW_B,
    OP_GEN_RD,
    OP_GEN_OUT,
    OP_GEN_NONE
  } mtg_op_e;

  typedef struct packed {
    mtg_op_e op;
  } mtg_cmd_t;

  typedef struct packed {
    logic unseeded;
    logic need_twist;
  } mtg_sts_t;

endpackage
`default_nettype wire

/* rtl/mersenne_twister_generator.sv */
// top level of the mt19937 mersenne twister generator
`default_nettype none
// mt19937 generator with a 624-word state held in a memory with one write
// and two registered read ports. a word is accepted when start is high and
// busy is low; the receiver cannot stall, so each result shows on number_o
// and success_o for exactly one cycle with strobe_o high. func 2 (generate)
// reads the next state word into a read port register, then tempers it into
// the output register; when the state has run out it first twists all 624
// words, one word at a time over the memory ports. generate before any
// seeding answers in the next cycle with success 0 and number 0. func 0
// (single-word seed) runs the seed recurrence one word at a time through the
// shared multiplier. func 1 stores a key word; the word marked last also
// runs the array seeding (seed from the base word, then 624 key mixing and
// 623 final mixing steps, each through the multiplier). key words past the
// 32-entry key store are dropped. func 3 is ignored.
module mersenne_twister_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic [31:0] value_i,
  input  logic        last_key_i,
  output logic [31:0] number_o,
  output logic        success_o,
  output logic        strobe_o
);
  import mtg_pkg::*;

  mtg_cmd_t cmd;
  mtg_sts_t sts;

  // sequencer for every operation
  mtg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .func_i     (func_i),
    .last_key_i (last_key_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  // state memory, key store, multiplier and tempering
  mtg_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .value_i   (value_i),
    .sts_o     (sts),
    .number_o  (number_o),
    .success_o (success_o),
    .strobe_o  (strobe_o)
  );

endmodule
`default_nettype wire

/* rtl/mtg_dp.sv */
// datapath: state and key memories, shared multiplier, twist and tempering
`default_nettype none
module mtg_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mtg_pkg::mtg_cmd_t cmd_i,
  input  logic [31:0]      value_i,
  output mtg_pkg::mtg_sts_t sts_o,
  output logic [31:0]      number_o,
  output logic             success_o,
  output logic             strobe_o
);
  import mtg_pkg::*;

  logic [31:0] tw_mem  [STATE_WORDS];
  logic [31:0] key_mem [KEY_DEPTH];

  logic [IDX_W-1:0]  i_q, idx_q;
  logic [KEY_AW-1:0] j_q;
  logic [KC_W-1:0]   kc_q;
  logic [31:0] prev_q, prod_q, cur_q, rd0_q, rd1_q, key_rd_q, number_q;
  logic        success_q, strobe_q;

  logic [31:0] mix, mconst, prod_d, y, tw_w, seed_w, b1_w, b2_w;
  logic [IDX_W-1:0] i_wrap, nxt_addr, far_sum, far_addr, raddr0;
  logic [KC_W-1:0]  j_inc;
  logic        we, rd0_en, rd1_en, key_we;
  logic [IDX_W-1:0] waddr;
  logic [31:0] wdata;

  function automatic logic [31:0] temper(input logic [31:0] v);
    logic [31:0] t;
    t = v ^ (v >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    t = t ^ (t >> 18);
    return t;
  endfunction

  assign mix = prev_q ^ (prev_q >> 30);

  always_comb begin
    case (cmd_i.op)
      OP_A1:   mconst = ARRAY_MULT1;
      OP_A2:   mconst = ARRAY_MULT2;
      default: mconst = SEED_MULT;
    endcase
  end

  assign prod_d = 32'(mix * mconst);

  assign i_wrap   = (i_q == IDX_W'(STATE_WORDS - 1)) ? IDX_W'(1) : i_q + IDX_W'(1);
  assign nxt_addr = (i_q == IDX_W'(STATE_WORDS - 1)) ? '0 : i_q + IDX_W'(1);
  assign far_sum  = i_q + SHIFT_POS;
  assign far_addr = (far_sum >= IDX_W'(STATE_WORDS)) ? far_sum - IDX_W'(STATE_WORDS)
                                                     : far_sum;
  assign j_inc    = KC_W'(j_q) + KC_W'(1);

  assign seed_w = prod_q + 32'(i_q);
  assign b1_w   = (rd0_q ^ prod_q) + key_rd_q + 32'(j_q);
  assign b2_w   = (rd0_q ^ prod_q) - 32'(i_q);
  assign y      = {cur_q[31], rd0_q[30:0]};
  assign tw_w   = rd1_q ^ (y >> 1) ^ (y[0] ? TWIST_CONST : 32'd0);

  always_comb begin
    we     = 1'b0;
    waddr  = i_q;
    wdata  = tw_w;
    rd0_en = 1'b0;
    rd1_en = 1'b0;
    raddr0 = i_q;
    case (cmd_i.op)
      OP_SEED0:      begin we = 1'b1; waddr = '0; wdata = value_i; end
      OP_SEED0_BASE: begin we = 1'b1; waddr = '0; wdata = ARRAY_BASE; end
      OP_SEED_WR:    begin we = 1'b1; wdata = seed_w; end
      OP_A1, OP_A2:  rd0_en = 1'b1;
      OP_B1:         begin we = 1'b1; wdata = b1_w; end
      OP_B2:         begin we = 1'b1; wdata = b2_w; end
      OP_FIN:        begin we = 1'b1; waddr = '0; wdata = HIGH_BIT; end
      OP_TW_PRE:     begin rd0_en = 1'b1; raddr0 = '0; end
      OP_TW_A:       begin rd0_en = 1'b1; rd1_en = 1'b1; raddr0 = nxt_addr; end
      OP_TW_B:       we = 1'b1;
      OP_GEN_RD:     begin rd0_en = 1'b1; raddr0 = idx_q; end
      default:       ;
    endcase
  end

  assign key_we = (cmd_i.op == OP_KEY) && (kc_q < KC_W'(KEY_DEPTH));

  // memories
  always_ff @(posedge clk_i) begin
    if (we) tw_mem[waddr] <= wdata;
    if (rd0_en) rd0_q <= tw_mem[raddr0];
    if (rd1_en) rd1_q <= tw_mem[far_addr];
    if (key_we) key_mem[kc_q[KEY_AW-1:0]] <= value_i;
    if (cmd_i.op == OP_A1) key_rd_q <= key_mem[j_q];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_SEED0:      prev_q <= value_i;
      OP_SEED0_BASE: prev_q <= ARRAY_BASE;
      OP_SEED_WR:    prev_q <= seed_w;
      OP_ARR_INIT:   prev_q <= ARRAY_BASE;
      OP_B1:         prev_q <= b1_w;
      OP_B2:         prev_q <= b2_w;
      default:       ;
    endcase
    if (cmd_i.op == OP_SEED_MUL || cmd_i.op == OP_A1 || cmd_i.op == OP_A2) prod_q <= prod_d;
    if (cmd_i.op == OP_TW_A) cur_q <= rd0_q;
    if (cmd_i.op == OP_GEN_OUT) begin
      number_q  <= temper(rd0_q);
      success_q <= 1'b1;
    end else if (cmd_i.op == OP_GEN_NONE) begin
      number_q  <= '0;
      success_q <= 1'b0;
    end
  end

  // counters and strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q      <= '0;
      j_q      <= '0;
      idx_q    <= UNSEEDED;
      kc_q     <= '0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= (cmd_i.op == OP_GEN_OUT) || (cmd_i.op == OP_GEN_NONE);
      case (cmd_i.op)
        OP_SEED0: begin
          i_q   <= IDX_W'(1);
          idx_q <= IDX_W'(STATE_WORDS);
        end
        OP_SEED0_BASE: begin
          i_q <= IDX_W'(1);
          j_q <= '0;
        end
        OP_SEED_WR: i_q <= i_q + IDX_W'(1);
        OP_KEY: if (key_we) kc_q <= kc_q + KC_W'(1);
        OP_ARR_INIT: i_q <= IDX_W'(1);
        OP_B1: begin
          i_q <= i_wrap;
          j_q <= (j_inc >= kc_q) ? '0 : KEY_AW'(j_inc);
        end
        OP_B2: i_q <= i_wrap;
        OP_FIN: begin
          kc_q  <= '0;
          idx_q <= IDX_W'(STATE_WORDS);
        end
        OP_TW_PRE: begin
          i_q   <= '0;
          idx_q <= '0;
        end
        OP_TW_B:    i_q <= i_q + IDX_W'(1);
        OP_GEN_OUT: idx_q <= idx_q + IDX_W'(1);
        default:    ;
      endcase
    end
  end

  assign sts_o.unseeded   = (idx_q >= UNSEEDED);
  assign sts_o.need_twist = (idx_q >= IDX_W'(STATE_WORDS)) && (idx_q < UNSEEDED);
  assign number_o  = number_q;
  assign success_o = success_q;
  assign strobe_o  = strobe_q;

endmodule
`default_nettype wire

/* rtl/mtg_ctrl.sv */
// controller: sequences seeding, array seeding, twist and generate
`default_nettype none
module mtg_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [1:0]       func_i,
  input  logic             last_key_i,
  input  mtg_pkg::mtg_sts_t sts_i,
  output mtg_pkg::mtg_cmd_t cmd_o,
  output logic             busy_o
);
  import mtg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ARR_BASE, S_SEED_MUL, S_SEED_WR, S_ARR_INIT, S_A1, S_B1, S_A2, S_B2,
    S_FIN, S_TW_A, S_TW_B, S_GEN_RD, S_GEN_OUT
  } state_e;

  state_e state_q;
  logic [IDX_W-1:0] cnt_q;
  logic arr_q;

  always_comb begin
    cmd_o.op = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (func_i)
            FUNC_SEED: cmd_o.op = OP_SEED0;
            FUNC_KEY:  cmd_o.op = OP_KEY;
            FUNC_GEN: begin
              if (sts_i.unseeded)        cmd_o.op = OP_GEN_NONE;
              else if (sts_i.need_twist) cmd_o.op = OP_TW_PRE;
              else                       cmd_o.op = OP_GEN_RD;
            end
            default: cmd_o.op = OP_NONE;
          endcase
        end
      end
      S_ARR_BASE: cmd_o.op = OP_SEED0_BASE;
      S_SEED_MUL: cmd_o.op = OP_SEED_MUL;
      S_SEED_WR:  cmd_o.op = OP_SEED_WR;
      S_ARR_INIT: cmd_o.op = OP_ARR_INIT;
      S_A1:       cmd_o.op = OP_A1;
      S_B1:       cmd_o.op = OP_B1;
      S_A2:       cmd_o.op = OP_A2;
      S_B2:       cmd_o.op = OP_B2;
      S_FIN:      cmd_o.op = OP_FIN;
      S_TW_A:     cmd_o.op = OP_TW_A;
      S_TW_B:     cmd_o.op = OP_TW_B;
      S_GEN_RD:   cmd_o.op = OP_GEN_RD;
      S_GEN_OUT:  cmd_o.op = OP_GEN_OUT;
      default:    cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      arr_q   <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            case (cmd_o.op)
              OP_SEED0: begin
                state_q <= S_SEED_MUL;
                arr_q   <= 1'b0;
                cnt_q   <= IDX_W'(STATE_WORDS - 2);
              end
              OP_KEY: if (last_key_i) state_q <= S_ARR_BASE;
              OP_TW_PRE: begin
                state_q <= S_TW_A;
                cnt_q   <= IDX_W'(STATE_WORDS - 1);
              end
              OP_GEN_RD: state_q <= S_GEN_OUT;
              default: ;
            endcase
          end
        end
        S_ARR_BASE: begin
          state_q <= S_SEED_MUL;
          arr_q   <= 1'b1;
          cnt_q   <= IDX_W'(STATE_WORDS - 2);
        end
        S_SEED_MUL: state_q <= S_SEED_WR;
        S_SEED_WR: begin
          if (cnt_q == '0) begin
            if (arr_q) begin
              state_q <= S_ARR_INIT;
            end else begin
              state_q <= S_IDLE;
            end
          end else begin
            state_q <= S_SEED_MUL;
            cnt_q   <= cnt_q - IDX_W'(1);
          end
        end
        S_ARR_INIT: begin
          state_q <= S_A1;
          cnt_q   <= IDX_W'(STATE_WORDS - 1);
        end
        S_A1: state_q <= S_B1;
        S_B1: begin
          if (cnt_q == '0) begin
            state_q <= S_A2;
            cnt_q   <= IDX_W'(STATE_WORDS - 2);
          end else begin
            state_q <= S_A1;
            cnt_q   <= cnt_q - IDX_W'(1);
          end
        end
        S_A2: state_q <= S_B2;
        S_B2: begin
          if (cnt_q == '0) begin
            state_q <= S_FIN;
          end else begin
            state_q <= S_A2;
            cnt_q   <= cnt_q - IDX_W'(1);
          end
        end
        S_FIN:  state_q <= S_IDLE;
        S_TW_A: state_q <= S_TW_B;
        S_TW_B: begin
          if (cnt_q == '0) begin
            state_q <= S_GEN_RD;
          end else begin
            state_q <= S_TW_A;
            cnt_q   <= cnt_q - IDX_W'(1);
          end
        end
        S_GEN_RD:  state_q <= S_GEN_OUT;
        S_GEN_OUT: state_q <= S_IDLE;
        default:   state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule
`default_nettype wire

/* rtl/mtg_checker.sv */
// port-level checks of the mersenne twister generator and their binding
`default_nettype none
module mtg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [1:0]  func_i,
  input logic [31:0] number_o,
  input logic        success_o,
  input logic        strobe_o
);
  import mtg_pkg::*;

  // a failed generate carries a zero word
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !success_o |-> number_o == 32'd0)
    else $error("failed generate with nonzero word");

  // seed and key words never give a result in the next cycle
  a_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && func_i != FUNC_GEN |=> !strobe_o)
    else $error("result after a non-generate word");

  // a result follows a generate or ongoing work
  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(busy) || ($past(start) && $past(func_i) == FUNC_GEN))
    else $error("result without a generate");

  // single-word seeding keeps the block busy
  a_seed_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && func_i == FUNC_SEED |=> busy)
    else $error("seeding finished at once");

endmodule

bind mersenne_twister_generator mtg_checker u_mtg_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start     (start),
  .busy      (busy),
  .func_i    (func_i),
  .number_o  (number_o),
  .success_o (success_o),
  .strobe_o  (strobe_o)
);
`default_nettype wire

/* dv/tb_mersenne_twister_generator.sv */
// self-checking testbench for the mt19937 mersenne twister generator
`timescale 1ns / 1ps
module tb_mersenne_twister_generator;
  import mtg_pkg::*;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] value;
    logic        last_key;
  } cmd_word_t;

  typedef struct packed {
    logic [31:0] number;
    logic        success;
  } gen_word_t;

  localparam int unsigned MAX_CYCLES = 20_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  func_i = FUNC_SEED;
  logic [31:0] value_i = '0;
  logic        last_key_i = 1'b0;
  logic [31:0] number_o;
  logic        success_o;
  logic        strobe_o;

  mersenne_twister_generator DUT (
    .clk_i, .rst_ni, .start, .busy, .func_i, .value_i, .last_key_i,
    .number_o, .success_o, .strobe_o
  );

  always #4 clk_i = ~clk_i;

  // predictor state, kept apart from the block
  logic [31:0] mt_words [STATE_WORDS];
  logic [31:0] mt_keys [KEY_DEPTH];
  int unsigned mt_index = 625;
  int unsigned mt_key_count = 0;

  cmd_word_t   cmd_queue [$];
  gen_word_t   gen_expected [$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 10;
  bit          hold_send = 1'b0;

  function automatic void mt_seed_word(logic [31:0] s);
    mt_words[0] = s;
    for (int i = 1; i < STATE_WORDS; i++)
      mt_words[i] = SEED_MULT * (mt_words[i-1] ^ (mt_words[i-1] >> 30)) + 32'(i);
    mt_index = STATE_WORDS;
  endfunction

  // 2002 init_by_array over the stored key words
  function automatic void mt_seed_keys(int unsigned len);
    int unsigned i, j, k;
    logic [31:0] p;
    i = 1;
    j = 0;
    mt_seed_word(ARRAY_BASE);
    if (len == 0) len = 1;
    k = (STATE_WORDS > len) ? STATE_WORDS : len;
    for (; k > 0; k--) begin
      p = mt_words[i-1];
      mt_words[i] = (mt_words[i] ^ ((p ^ (p >> 30)) * ARRAY_MULT1)) + mt_keys[j] + 32'(j);
      i++;
      j++;
      if (i >= STATE_WORDS) begin
        mt_words[0] = mt_words[STATE_WORDS-1];
        i = 1;
      end
      if (j >= len) j = 0;
    end
    for (k = STATE_WORDS - 1; k > 0; k--) begin
      p = mt_words[i-1];
      mt_words[i] = (mt_words[i] ^ ((p ^ (p >> 30)) * ARRAY_MULT2)) - 32'(i);
      i++;
      if (i >= STATE_WORDS) begin
        mt_words[0] = mt_words[STATE_WORDS-1];
        i = 1;
      end
    end
    mt_words[0] = HIGH_BIT;
    mt_index = STATE_WORDS;
  endfunction

  function automatic void mt_twist();
    logic [31:0] y;
    for (int i = 0; i < STATE_WORDS; i++) begin
      y = (mt_words[i] & HIGH_BIT) | (mt_words[(i+1) % STATE_WORDS] & ~HIGH_BIT);
      mt_words[i] = mt_words[(i+397) % STATE_WORDS] ^ (y >> 1) ^ (y[0] ? TWIST_CONST : '0);
    end
    mt_index = 0;
  endfunction

  // advance the predictor by one accepted word, queue any expected result
  function automatic void mt_predict(cmd_word_t c);
    logic [31:0] y;
    case (c.func)
      FUNC_SEED: mt_seed_word(c.value);
      FUNC_KEY: begin
        if (mt_key_count < KEY_DEPTH) begin
          mt_keys[mt_key_count] = c.value;
          mt_key_count++;
        end
        if (c.last_key) begin
          mt_seed_keys(mt_key_count);
          mt_key_count = 0;
        end
      end
      FUNC_GEN: begin
        if (mt_index >= 625) begin
          gen_expected.push_back('{number: '0, success: 1'b0});
        end else begin
          if (mt_index >= STATE_WORDS) mt_twist();
          y = mt_words[mt_index];
          mt_index++;
          y ^= y >> 11;
          y ^= (y << 7) & TEMPER_B;
          y ^= (y << 15) & TEMPER_C;
          y ^= y >> 18;
          gen_expected.push_back('{number: y, success: 1'b1});
        end
      end
      default: ;
    endcase
  endfunction

  // driver: one word per handshake, random gaps, optional hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) mt_predict('{func: func_i, value: value_i, last_key: last_key_i});
      if (start && busy) begin
        // keep the offered word until it is taken
      end else if (cmd_queue.size() > 0 && !hold_send &&
                   $urandom_range(99) >= send_idle_pct) begin
        start      <= 1'b1;
        func_i     <= cmd_queue[0].func;
        value_i    <= cmd_queue[0].value;
        last_key_i <= cmd_queue[0].last_key;
        void'(cmd_queue.pop_front());
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: results cannot be held off, check each strobe
  always @(posedge clk_i) begin
    gen_word_t exp_word;
    if (rst_ni && strobe_o) begin
      if (gen_expected.size() == 0) begin
        $error("unexpected result number=%h success=%b", number_o, success_o);
        fail_count++;
      end else begin
        exp_word = gen_expected.pop_front();
        if (number_o !== exp_word.number) begin
          $error("number: expected %h actual %h", exp_word.number, number_o);
          fail_count++;
        end
        if (success_o !== exp_word.success) begin
          $error("success: expected %b actual %b", exp_word.success, success_o);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic cmd_word_t mk(logic [1:0] f, logic [31:0] v, logic l);
    return '{func: f, value: v, last_key: l};
  endfunction

  task automatic drain();
    while (cmd_queue.size() > 0 || start || busy || gen_expected.size() > 0)
      @(posedge clk_i);
  endtask

  task automatic random_phase(int unsigned n);
    int unsigned r, len;
    for (int unsigned k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 70) begin
        cmd_queue.push_back(mk(FUNC_GEN, $urandom, 1'($urandom_range(1))));
      end else if (r < 76) begin
        cmd_queue.push_back(mk(FUNC_SEED, $urandom, 1'($urandom_range(1))));
      end else if (r < 80) begin
        // well-formed key of random length, sometimes past the store
        len = ($urandom_range(9) == 0) ? $urandom_range(33, 36) : $urandom_range(1, 6);
        for (int unsigned q = 0; q < len; q++)
          cmd_queue.push_back(mk(FUNC_KEY, $urandom, q == len - 1));
      end else if (r < 84) begin
        cmd_queue.push_back(mk(FUNC_KEY, $urandom, 1'b0));
      end else begin
        cmd_queue.push_back(mk(2'd3, $urandom, 1'($urandom_range(1))));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: unseeded generate, unused code, extremes, reference key
    cmd_queue.push_back(mk(FUNC_GEN, 32'hFFFF_FFFF, 1'b1));
    cmd_queue.push_back(mk(2'd3, 32'hFFFF_FFFF, 1'b1));
    cmd_queue.push_back(mk(FUNC_GEN, '0, 1'b0));
    cmd_queue.push_back(mk(FUNC_SEED, 32'd5489, 1'b1));
    cmd_queue.push_back(mk(FUNC_GEN, '0, 1'b0));
    cmd_queue.push_back(mk(FUNC_GEN, '0, 1'b0));
    cmd_queue.push_back(mk(FUNC_SEED, '0, 1'b0));
    cmd_queue.push_back(mk(FUNC_GEN, '0, 1'b0));
    cmd_queue.push_back(mk(FUNC_SEED, 32'hFFFF_FFFF, 1'b0));
    cmd_queue.push_back(mk(FUNC_GEN, '0, 1'b0));
    cmd_queue.push_back(mk(FUNC_KEY, 32'h123, 1'b0));
    cmd_queue.push_back(mk(FUNC_KEY, 32'h234, 1'b0));
    cmd_queue.push_back(mk(FUNC_SEED, 32'h1, 1'b0));  // seed between key words
    cmd_queue.push_back(mk(FUNC_KEY, 32'h345, 1'b0));
    cmd_queue.push_back(mk(FUNC_KEY, 32'h456, 1'b1));
    cmd_queue.push_back(mk(FUNC_GEN, '0, 1'b0));
    cmd_queue.push_back(mk(FUNC_KEY, 32'hFFFF_FFFF, 1'b1));  // one-word key
    cmd_queue.push_back(mk(FUNC_GEN, '0, 1'b0));
    // full key store, then dropped words, the last one marked
    for (int unsigned q = 0; q < 34; q++)
      cmd_queue.push_back(mk(FUNC_KEY, $urandom, q == 33));
    cmd_queue.push_back(mk(FUNC_GEN, '0, 1'b0));
    drain();

    // queue a random phase and hold the sender off before draining it
    random_phase(20);
    hold_send = 1'b1;
    repeat (3) @(posedge clk_i);
    hold_send = 1'b0;
    drain();

    send_idle_pct = 10;
    random_phase(200);
    drain();
    send_idle_pct = 49;
    random_phase(190);
    drain();
    send_idle_pct = 0;
    random_phase(200);
    drain();

    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && gen_expected.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
